// ===== rtl/hhs_pkg.sv =====
// ----------------------------------------------------------------------------
// hhs_pkg
// Shared types and constants for the heightmap height sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package hhs_pkg;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_SCALE_Z    = 2'd2;
   localparam logic [1:0] CSR_INV_TILE   = 2'd3;

   // Item kinds on the request channel
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Result offset: 4.0 in Q.8
   localparam logic [26:0] HEIGHT_BIAS = 27'd1024;

   // Effective configuration handed from the register file to the datapath
   typedef struct packed {
      logic [8:0]  map_w;      // clamped to 1..MAX_WIDTH
      logic [8:0]  map_h;      // clamped to 1..MAX_HEIGHT
      logic [15:0] scale_z;    // Q8.8
      logic [15:0] inv_tile;   // Q8.8
   } cfg_type;

   // Query sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_BASE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_MUL,
      ST_SUM
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/hhs_ram.sv =====
// ----------------------------------------------------------------------------
// hhs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hhs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One access per cycle: write, or read into the output register
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata <= mem_ff[addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hhs_csr.sv =====
// ----------------------------------------------------------------------------
// hhs_csr
// Configuration registers; presents map size clamped to the grid limits.
// ----------------------------------------------------------------------------
`default_nettype none

module hhs_csr #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [1:0]     csr_index,
   input  wire logic [15:0]    csr_data,
   output hhs_pkg::cfg_type    cfg
);

   logic [8:0]  map_w_ff,   map_w_in;
   logic [8:0]  map_h_ff,   map_h_in;
   logic [15:0] scale_z_ff, scale_z_in;
   logic [15:0] inv_ff,     inv_in;

   // No write beat is taken while reset is high
   assign csr_ready = !reset;

   // Write decode
   always_comb begin
      map_w_in   = map_w_ff;
      map_h_in   = map_h_ff;
      scale_z_in = scale_z_ff;
      inv_in     = inv_ff;
      if (csr_valid) begin
         unique case (csr_index)
            hhs_pkg::CSR_MAP_WIDTH:  map_w_in   = csr_data[8:0];
            hhs_pkg::CSR_MAP_HEIGHT: map_h_in   = csr_data[8:0];
            hhs_pkg::CSR_SCALE_Z:    scale_z_in = csr_data;
            hhs_pkg::CSR_INV_TILE:   inv_in     = csr_data;
            default:                 map_w_in   = map_w_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_w_ff   <= 9'd1;
         map_h_ff   <= 9'd1;
         scale_z_ff <= 16'd256;
         inv_ff     <= 16'd256;
      end else begin
         map_w_ff   <= map_w_in;
         map_h_ff   <= map_h_in;
         scale_z_ff <= scale_z_in;
         inv_ff     <= inv_in;
      end
   end

   // Dimensions clamped to 1..MAX
   always_comb begin
      if (map_w_ff == 9'd0) begin
         cfg.map_w = 9'd1;
      end else if (int'(map_w_ff) > MAX_WIDTH) begin
         cfg.map_w = 9'(MAX_WIDTH);
      end else begin
         cfg.map_w = map_w_ff;
      end
      if (map_h_ff == 9'd0) begin
         cfg.map_h = 9'd1;
      end else if (int'(map_h_ff) > MAX_HEIGHT) begin
         cfg.map_h = 9'(MAX_HEIGHT);
      end else begin
         cfg.map_h = map_h_ff;
      end
      cfg.scale_z  = scale_z_ff;
      cfg.inv_tile = inv_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/heightmap_height_sampler.sv =====
// ----------------------------------------------------------------------------
// heightmap_height_sampler
// Grid height store with three-corner interpolated height queries.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one beat is a load (req_action=0) or a query (req_action=1).
//    A load writes sample*scale_z at the next row-major grid address;
//    req_first restarts the address at zero. Loads give no rsp_ beat.
//  - rsp_ channel: one beat per query, carrying ground_height in Q.8.
//  - csr_ channel: register writes, ready while reset is low; write only while idle.
// Timing:
//  - Loads stream at one beat per cycle while no query is in progress.
//  - A query runs these steps before the next request is taken: multiply,
//    clamp, row base, three reads of the single-port grid RAM, blend, sum.
//    The single RAM port, read once per corner, sets the read phase.
//    Its rsp_ beat is written to the output register in the sum step.
//  - The result is in an output register; the next request is taken while
//    it waits. A stalled rsp_ready holds the sequencer in its last step
//    only if a second result is ready before the first is taken.
// Reset: clears the sequencer, the load address and the registers; no req_
//  or csr_ beat is taken while reset is high. The grid RAM is not cleared;
//  a map must be loaded before it is queried.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_height_sampler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_action,
   input  wire logic               req_first,
   input  wire logic [7:0]         req_sample,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   // response
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [26:0]      rsp_ground_height,
   // configuration
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   hhs_pkg::cfg_type   cfg;
   hhs_pkg::state_type state_ff, state_in;

   // Sequencer controls
   logic req_accept;
   logic out_free;
   logic mem_we;
   logic cap_h0, cap_h1, do_mul, do_sum;

   // Datapath registers
   logic [AW-1:0]      load_ptr_ff, load_ptr_in;
   logic [AW-1:0]      load_addr;
   logic [46:0]        prod_x_ff, prod_y_ff;
   logic [8:0]         x0_ff, x1_ff, y0_ff, y1_ff;
   logic [7:0]         fx_ff, fy_ff, fx_b_ff, fy_b_ff;
   logic [17:0]        row0_ff, row1_ff;
   logic [23:0]        h0_ff, h1_ff;
   logic signed [33:0] p1_ff, p2_ff;
   logic               rsp_valid_ff;
   logic [26:0]        rsp_data_ff;

   // Combinational intermediates
   logic [16:0]        sx, sy;
   logic [8:0]         xi, yi;
   logic [8:0]         w_last, h_last;
   logic [9:0]         xi_p1, yi_p1;
   logic [AW-1:0]      mem_addr;
   logic [23:0]        mem_wdata, mem_rdata;
   logic signed [24:0] d1, d2;
   logic signed [35:0] acc;

   hhs_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hhs_ram #(
      .WIDTH (24),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hhs_pkg::ST_IDLE: begin
            if (req_accept && req_action == hhs_pkg::ACT_QUERY) begin
               state_in = hhs_pkg::ST_CLAMP;
            end
         end
         hhs_pkg::ST_CLAMP: state_in = hhs_pkg::ST_BASE;
         hhs_pkg::ST_BASE:  state_in = hhs_pkg::ST_RD0;
         hhs_pkg::ST_RD0:   state_in = hhs_pkg::ST_RD1;
         hhs_pkg::ST_RD1:   state_in = hhs_pkg::ST_RD2;
         hhs_pkg::ST_RD2:   state_in = hhs_pkg::ST_MUL;
         hhs_pkg::ST_MUL:   state_in = hhs_pkg::ST_SUM;
         hhs_pkg::ST_SUM: begin
            if (out_free) begin
               state_in = hhs_pkg::ST_IDLE;
            end
         end
         default: state_in = hhs_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      cap_h0    = 1'b0;
      cap_h1    = 1'b0;
      do_mul    = 1'b0;
      do_sum    = 1'b0;
      mem_addr  = load_addr;
      unique case (state_ff)
         hhs_pkg::ST_IDLE: begin
            req_ready = !reset;
            mem_we    = req_valid && !reset && req_action == hhs_pkg::ACT_LOAD;
         end
         hhs_pkg::ST_RD0: mem_addr = AW'(row0_ff + 18'(x0_ff));
         hhs_pkg::ST_RD1: begin
            mem_addr = AW'(row0_ff + 18'(x1_ff));
            cap_h0   = 1'b1;
         end
         hhs_pkg::ST_RD2: begin
            mem_addr = AW'(row1_ff + 18'(x0_ff));
            cap_h1   = 1'b1;
         end
         hhs_pkg::ST_MUL: do_mul = 1'b1;
         hhs_pkg::ST_SUM: do_sum = out_free;
         default: mem_addr = load_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hhs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Load address: restart on first, wrap after the last entry
   assign load_addr = req_first ? '0 : load_ptr_ff;
   assign mem_wdata = 24'(req_sample) * 24'(cfg.scale_z);

   always_comb begin
      load_ptr_in = load_ptr_ff;
      if (mem_we) begin
         if (load_addr == AW'(DEPTH - 1)) begin
            load_ptr_in = '0;
         end else begin
            load_ptr_in = load_addr + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
      end else begin
         load_ptr_ff <= load_ptr_in;
      end
   end

   // Coordinate scaling; negative positions scale to zero
   always_ff @(posedge clock) begin
      if (req_accept) begin
         prod_x_ff <= req_pos_x[31] ? '0 : 47'(req_pos_x[30:0]) * 47'(cfg.inv_tile);
         prod_y_ff <= req_pos_y[31] ? '0 : 47'(req_pos_y[30:0]) * 47'(cfg.inv_tile);
      end
   end

   // Clamp to [0, dim*256], split into index and fraction
   always_comb begin
      if (prod_x_ff[46:8] > {22'd0, cfg.map_w, 8'd0}) begin
         sx = {cfg.map_w, 8'd0};
      end else begin
         sx = prod_x_ff[24:8];
      end
      if (prod_y_ff[46:8] > {22'd0, cfg.map_h, 8'd0}) begin
         sy = {cfg.map_h, 8'd0};
      end else begin
         sy = prod_y_ff[24:8];
      end
      xi     = sx[16:8];
      yi     = sy[16:8];
      w_last = cfg.map_w - 9'd1;
      h_last = cfg.map_h - 9'd1;
      xi_p1  = {1'b0, xi} + 10'd1;
      yi_p1  = {1'b0, yi} + 10'd1;
   end

   // Corner indices with edge replication
   always_ff @(posedge clock) begin
      if (state_ff == hhs_pkg::ST_CLAMP) begin
         x0_ff <= (xi < w_last) ? xi : w_last;
         y0_ff <= (yi < h_last) ? yi : h_last;
         x1_ff <= (xi_p1 < {1'b0, w_last}) ? xi_p1[8:0] : w_last;
         y1_ff <= (yi_p1 < {1'b0, h_last}) ? yi_p1[8:0] : h_last;
         fx_ff <= sx[7:0];
         fy_ff <= sy[7:0];
      end
   end

   // Row base addresses
   always_ff @(posedge clock) begin
      if (state_ff == hhs_pkg::ST_BASE) begin
         row0_ff <= 18'(y0_ff) * 18'(cfg.map_w);
         row1_ff <= 18'(y1_ff) * 18'(cfg.map_w);
         fx_b_ff <= fx_ff;
         fy_b_ff <= fy_ff;
      end
   end

   // Corner capture from the RAM read register
   always_ff @(posedge clock) begin
      if (cap_h0) begin
         h0_ff <= mem_rdata;
      end
      if (cap_h1) begin
         h1_ff <= mem_rdata;
      end
   end

   // Weighted differences; third corner comes straight from the RAM
   assign d1 = signed'({1'b0, h1_ff}) - signed'({1'b0, h0_ff});
   assign d2 = signed'({1'b0, mem_rdata}) - signed'({1'b0, h0_ff});

   always_ff @(posedge clock) begin
      if (do_mul) begin
         p1_ff <= 34'(d1) * 34'(signed'({1'b0, fx_b_ff}));
         p2_ff <= 34'(d2) * 34'(signed'({1'b0, fy_b_ff}));
      end
   end

   // Sum, floor divide by 256, add the 4.0 bias
   assign acc = signed'({4'd0, h0_ff, 8'd0}) + 36'(p1_ff) + 36'(p2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_sum) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_sum) begin
         rsp_data_ff <= acc[34:8] + hhs_pkg::HEIGHT_BIAS;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ground_height = signed'(rsp_data_ff);

   // A load never starts the query sequence
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == hhs_pkg::ACT_LOAD) |=> (state_ff == hhs_pkg::ST_IDLE))
      else $error("load beat left the idle state");

   // The grid is written only while idle
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == hhs_pkg::ST_IDLE))
      else $error("grid write during a query");

   // Finishing a query presents a result and returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == hhs_pkg::ST_SUM && out_free)
      |=> (rsp_valid_ff && state_ff == hhs_pkg::ST_IDLE))
      else $error("query result not presented");

   // Load address stays inside the grid
   assert property (@(posedge clock) disable iff (reset)
      (int'(load_ptr_ff) < DEPTH))
      else $error("load address beyond grid");

endmodule

`default_nettype wire

// ===== bench/heightmap_height_sampler_tb.sv =====
// ----------------------------------------------------------------------------
// heightmap_height_sampler_tb
// Self-checking bench for the grid height store and interpolated queries.
// ----------------------------------------------------------------------------
// A short directed table runs first: fixed answers on a 1x1 map, then a 2x2
// map with extreme scales and clamped dimensions. Random phases follow, each
// with its own register setting, the first few at the size extremes. Every
// phase loads a full map, then sends a mix of queries and reloads. Each
// query's height comes from a local mirror of the grid and the registers,
// and is compared in order with the rsp_ beats. Both channels idle and
// stall at random, with one phase run back to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heightmap_height_sampler_tb;

   localparam int GRID_MAX_W    = 256;
   localparam int GRID_MAX_H    = 256;
   localparam int NUM_PHASES    = 10;
   localparam int RANDOM_ITEMS  = 60;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int DIR_ROWS      = 26;

   // Short names for the codes used in the directed table
   localparam logic       LD = hhs_pkg::ACT_LOAD;
   localparam logic       QY = hhs_pkg::ACT_QUERY;
   localparam logic [1:0] RW = hhs_pkg::CSR_MAP_WIDTH;
   localparam logic [1:0] RH = hhs_pkg::CSR_MAP_HEIGHT;
   localparam logic [1:0] RS = hhs_pkg::CSR_SCALE_Z;
   localparam logic [1:0] RT = hhs_pkg::CSR_INV_TILE;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One directed row: an item beat or a register write
   typedef struct packed {
      row_kind_type        kind;
      logic                action;
      logic                first;
      logic [7:0]          sample;
      logic [31:0]         pos_x;
      logic [31:0]         pos_y;
      logic [1:0]          reg_index;   // unused on item rows
      logic [15:0]         reg_data;
      logic                typed;       // height below is the expected answer
      logic signed [26:0]  height;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = hhs_pkg::ACT_LOAD;
   logic               req_first = 1'b0;
   logic [7:0]         req_sample = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [26:0] rsp_ground_height;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = hhs_pkg::CSR_MAP_WIDTH;
   logic [15:0]        csr_data = '0;

   // Mirror of the block's state
   hhs_pkg::cfg_type cfg = '{map_w: 9'd1, map_h: 9'd1, scale_z: 16'd256, inv_tile: 16'd256};
   logic [23:0] grid_mirror [0:GRID_MAX_W*GRID_MAX_H-1];
   logic [15:0] load_ptr = '0;

   logic signed [26:0] height_q [$];
   logic signed [26:0] want_height;
   bit                 quiet = 1'b0;
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 load_count = 0;
   int                 query_count = 0;
   int                 setting_count = 0;

   // 1x1 map at reset values, then a 2x2 map with full scale and clamped dims
   stim_row_type dir_table [DIR_ROWS] = '{
      '{ROW_ITEM, LD, 1'b1, 8'hFF, 32'h0, 32'h0, RW, 16'h0, 1'b0, 27'd0},
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h0, 32'h0, RW, 16'h0, 1'b1, 27'd66304},
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, RW, 16'h0, 1'b1, 27'd66304},
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h8000_0000, 32'h8000_0000, RW, 16'h0, 1'b1, 27'd66304},
      '{ROW_ITEM, QY, 1'b1, 8'hAA, 32'hFFFF_FFFF, 32'h180, RW, 16'h0, 1'b1, 27'd66304},
      '{ROW_ITEM, LD, 1'b1, 8'h00, 32'h0, 32'h0, RW, 16'h0, 1'b0, 27'd0},
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h80, 32'h80, RW, 16'h0, 1'b1, 27'd1024},
      '{ROW_ITEM, LD, 1'b0, 8'h80, 32'h0, 32'h0, RW, 16'h0, 1'b0, 27'd0},
      '{ROW_ITEM, LD, 1'b1, 8'h01, 32'h0, 32'h0, RW, 16'h0, 1'b0, 27'd0},
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h100, 32'h0, RW, 16'h0, 1'b1, 27'd1280},
      '{ROW_CSR,  LD, 1'b0, 8'h00, 32'h0, 32'h0, RW, 16'd2, 1'b0, 27'd0},
      '{ROW_CSR,  LD, 1'b0, 8'h00, 32'h0, 32'h0, RH, 16'd2, 1'b0, 27'd0},
      '{ROW_CSR,  LD, 1'b0, 8'h00, 32'h0, 32'h0, RS, 16'hFFFF, 1'b0, 27'd0},
      '{ROW_CSR,  LD, 1'b0, 8'h00, 32'h0, 32'h0, RT, 16'h0080, 1'b0, 27'd0},
      '{ROW_ITEM, LD, 1'b1, 8'hFF, 32'h0, 32'h0, RW, 16'h0, 1'b0, 27'd0},
      '{ROW_ITEM, LD, 1'b0, 8'h00, 32'h0, 32'h0, RW, 16'h0, 1'b0, 27'd0},
      '{ROW_ITEM, LD, 1'b0, 8'h00, 32'h0, 32'h0, RW, 16'h0, 1'b0, 27'd0},
      '{ROW_ITEM, LD, 1'b0, 8'h7F, 32'h0, 32'h0, RW, 16'h0, 1'b0, 27'd0},
      // both fractions at 255: the blend goes negative
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h1FE, 32'h1FE, RW, 16'h0, 1'b0, 27'd0},
      // far column: right corner clamps to the last column
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h300, 32'h100, RW, 16'h0, 1'b0, 27'd0},
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h7FFF_FFFF, 32'h0, RW, 16'h0, 1'b0, 27'd0},
      '{ROW_CSR,  LD, 1'b0, 8'h00, 32'h0, 32'h0, RT, 16'h0000, 1'b0, 27'd0},
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h1234_5678, 32'h7FFF_FFFF, RW, 16'h0, 1'b0, 27'd0},
      // width below range and height above range both clamp
      '{ROW_CSR,  LD, 1'b0, 8'h00, 32'h0, 32'h0, RW, 16'h0000, 1'b0, 27'd0},
      '{ROW_CSR,  LD, 1'b0, 8'h00, 32'h0, 32'h0, RH, 16'h01FF, 1'b0, 27'd0},
      '{ROW_ITEM, QY, 1'b0, 8'h00, 32'h100, 32'h100, RW, 16'h0, 1'b0, 27'd0}
   };

   heightmap_height_sampler dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_first         (req_first),
      .req_sample        (req_sample),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ground_height (rsp_ground_height),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Map dimension as the block uses it
   function automatic int unsigned eff_dim(logic [8:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return 32'(v);
   endfunction

   // World Q24.8 to grid Q.8, clamped to [0, dim*256]
   function automatic logic [16:0] grid_coord(logic [31:0] pos, int unsigned dim);
      logic [47:0] prod;
      logic [47:0] lim;
      lim = 48'(dim) << 8;
      if (pos[31]) return '0;
      prod = 48'(pos) * 48'(cfg.inv_tile);
      prod = prod >> 8;
      if (prod > lim) return lim[16:0];
      return prod[16:0];
   endfunction

   // Three-corner blend plus the 4.0 bias
   function automatic logic signed [26:0] predict_height(logic [31:0] px, logic [31:0] py);
      int unsigned w, h, xi, yi, x0, x1, y0, y1;
      logic [16:0] sx, sy;
      longint      fx, fy, h0, h1, h3, acc;
      w = eff_dim(cfg.map_w, GRID_MAX_W);
      h = eff_dim(cfg.map_h, GRID_MAX_H);
      sx = grid_coord(px, w);
      sy = grid_coord(py, h);
      xi = 32'(sx[16:8]);
      yi = 32'(sy[16:8]);
      fx = longint'(sx[7:0]);
      fy = longint'(sy[7:0]);
      x0 = (xi < w - 1) ? xi : w - 1;
      x1 = (xi + 1 < w - 1) ? xi + 1 : w - 1;
      y0 = (yi < h - 1) ? yi : h - 1;
      y1 = (yi + 1 < h - 1) ? yi + 1 : h - 1;
      h0 = longint'(grid_mirror[y0 * w + x0]);
      h1 = longint'(grid_mirror[y0 * w + x1]);
      h3 = longint'(grid_mirror[y1 * w + x0]);
      acc = h0 * 256 + fx * (h1 - h0) + fy * (h3 - h0);
      acc = (acc >>> 8) + longint'(hhs_pkg::HEIGHT_BIAS);
      return acc[26:0];
   endfunction

   // Query coordinate: mostly inside the map, some on the far edge,
   // some just below zero, some anywhere
   function automatic logic [31:0] world_coord(int unsigned dim);
      longint target;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: target = longint'(dim) * 256;
         2: target = -longint'($urandom_range(1, 4096));
         default: target = longint'($urandom_range(0, dim * 256 + 255));
      endcase
      if (cfg.inv_tile == 0) return $urandom;
      target = (target * 256) / longint'(cfg.inv_tile);
      return target[31:0];
   endfunction

   // Send one request beat and update the mirror when it is taken
   task automatic send_item(input logic act, input logic frst, input logic [7:0] samp,
                            input logic [31:0] px, input logic [31:0] py,
                            input logic typed, input logic signed [26:0] typed_height);
      if (!quiet && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_first  <= frst;
      req_sample <= samp;
      req_pos_x  <= px;
      req_pos_y  <= py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (act == hhs_pkg::ACT_LOAD) begin
         if (frst) load_ptr = '0;
         grid_mirror[load_ptr] = 24'(samp) * 24'(cfg.scale_z);
         load_ptr = load_ptr + 1'b1;
         load_count++;
      end else begin
         height_q.push_back(typed ? typed_height : predict_height(px, py));
         query_count++;
      end
   endtask

   // Hold off the sender until every height is back and the block is quiet
   task automatic idle_wait();
      req_valid <= 1'b0;
      while (height_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write beat; the caller lowers csr_valid afterwards
   task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         hhs_pkg::CSR_MAP_WIDTH:  cfg.map_w    = data[8:0];
         hhs_pkg::CSR_MAP_HEIGHT: cfg.map_h    = data[8:0];
         hhs_pkg::CSR_SCALE_Z:    cfg.scale_z  = data;
         hhs_pkg::CSR_INV_TILE:   cfg.inv_tile = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [8:0] w, input logic [8:0] h,
                            input logic [15:0] scale, input logic [15:0] inv);
      idle_wait();
      write_reg(hhs_pkg::CSR_MAP_WIDTH, 16'(w));
      write_reg(hhs_pkg::CSR_MAP_HEIGHT, 16'(h));
      write_reg(hhs_pkg::CSR_SCALE_Z, scale);
      write_reg(hhs_pkg::CSR_INV_TILE, inv);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // Fill the whole effective map in row-major order
   task automatic load_map();
      int unsigned cells;
      cells = eff_dim(cfg.map_w, GRID_MAX_W) * eff_dim(cfg.map_h, GRID_MAX_H);
      for (int unsigned n = 0; n < cells; n++)
         send_item(hhs_pkg::ACT_LOAD, n == 0, 8'($urandom), $urandom, $urandom, 1'b0, '0);
   endtask

   // Result checker and random rsp_ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (height_q.size() == 0) begin
            $error("ground_height: unexpected beat, got %0d", rsp_ground_height);
            error_count++;
         end else begin
            want_height = height_q.pop_front();
            if (rsp_ground_height !== want_height) begin
               $error("ground_height: expected %0d, got %0d", want_height,
                      rsp_ground_height);
               error_count++;
            end
         end
      end
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 21);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [8:0]  w, h;
      logic [15:0] scale, inv;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_table[r].kind == ROW_CSR) begin
            idle_wait();
            write_reg(dir_table[r].reg_index, dir_table[r].reg_data);
            csr_valid <= 1'b0;
         end else begin
            send_item(dir_table[r].action, dir_table[r].first, dir_table[r].sample,
                      dir_table[r].pos_x, dir_table[r].pos_y, dir_table[r].typed,
                      dir_table[r].height);
         end
      end

      // Random phases, the first few at the register extremes
      for (int p = 0; p < NUM_PHASES; p++) begin
         w     = 9'($urandom_range(1, 8));
         h     = 9'($urandom_range(1, 8));
         scale = 16'($urandom_range(0, 65535));
         inv   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(16, 1024));
         case (p)
            0: begin w = 9'd1;   h = 9'd256; inv = 16'd256; end
            1: begin w = 9'd256; h = 9'd1;   scale = 16'hFFFF; end
            2: begin w = 9'd0;   h = 9'd0;   scale = 16'h0000; inv = 16'hFFFF; end
            3: begin w = 9'd511; h = 9'd0;   inv = 16'd1; end
            4: begin w = 9'd1;   h = 9'd300; end
            default: ;
         endcase
         configure(w, h, scale, inv);
         quiet = (p == 1);
         load_map();
         for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // mid-phase drain on every other phase
            if (p % 2 == 0 && i == RANDOM_ITEMS / 2) idle_wait();
            if ($urandom_range(0, 99) < 72)
               send_item(hhs_pkg::ACT_QUERY, 1'($urandom), 8'($urandom),
                         world_coord(eff_dim(cfg.map_w, GRID_MAX_W)),
                         world_coord(eff_dim(cfg.map_h, GRID_MAX_H)), 1'b0, '0);
            else
               send_item(hhs_pkg::ACT_LOAD, $urandom_range(0, 9) == 0, 8'($urandom),
                         $urandom, $urandom, 1'b0, '0);
         end
         quiet = 1'b0;
      end

      idle_wait();
      $display("Ran %0d loads and %0d height queries over %0d register settings,",
               load_count, query_count, setting_count + 1);
      $display("including clamped dimensions, extreme scales and edge clamping.");
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hhs_pkg.sv
rtl/hhs_ram.sv
rtl/hhs_csr.sv
rtl/heightmap_height_sampler.sv
bench/heightmap_height_sampler_tb.sv
